### design/bloom_filter_membership_check_defines.svh
// Assertion macros used by the main design file.
`ifndef BLOOM_FILTER_MEMBERSHIP_CHECK_DEFINES_SVH
`define BLOOM_FILTER_MEMBERSHIP_CHECK_DEFINES_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define BFMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define BFMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

### design/bfmc_pkg.sv
// ----------------------------------------------------------------------------
// bfmc_pkg: shared types and constants
// Constants, hash constants and state types of the Bloom membership check.
// ----------------------------------------------------------------------------
package bfmc_pkg;

   localparam int unsigned TABLE_WORDS_DEF = 1024;
   localparam int unsigned MAX_HASHES_DEF  = 32;

   localparam int unsigned SIZE_W   = 17;
   localparam int unsigned HCNT_W   = 7;
   localparam int unsigned PADDR_W  = 5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
   localparam logic [1:0] REG_HASH_COUNT = 2'd1;
   localparam logic [1:0] REG_HASH_SEED  = 2'd2;

   localparam logic [16:0] SIZE_RESET  = 17'd65536;
   localparam logic [5:0]  COUNT_RESET = 6'd7;

   localparam logic [63:0] PR64_1   = 64'h9E3779B185EBCA87;
   localparam logic [63:0] PR64_2   = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] PR32_2M1 = 64'h0000000085EBCA76;
   localparam logic [63:0] SEC_A    = 64'h78E5C0CC4EE679CB ^ 64'h2172FFCC7DD05A82;
   localparam logic [63:0] SEC_B    = 64'h8E2443F7744608B8 ^ 64'h4C263A81E69035E0;
   localparam logic [63:0] AVAL_MUL = 64'h165667919E3779F9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_PROBE,
      ST_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_MUL,
      HS_ACC,
      HS_SETUP
   } hash_state_type;

endpackage

### design/bloom_filter_membership_check.sv
// ----------------------------------------------------------------------------
// bloom_filter_membership_check: Bloom filter test of 16-byte keys
// Loads table words and checks keys with double hashing over the table.
// ----------------------------------------------------------------------------
// Usage: the request channel carries load and query items, each a transfer
// taken when req_valid is high and req_stall low. A load writes one 64-bit
// table word and is finished in the cycle of its transfer; it gives no result.
// A query gives one result on the rsp channel: present, the running count of
// present keys in the batch, and the batch end flag.
// A query passes through its steps in order, with n the hash_count capped
// at 32: the key hash in the hash unit, whose 64-bit products share one
// 32x32 multiplier in 18 partial products, and its hand-over; three
// remainders by the table size taken four bits per cycle; one table read
// per probe from the single-port table memory for n probes, then the drain
// of the last read; and the load of the result.
// One query is worked at a time; req_stall is high until its result has
// been placed in the output register, and loads wait likewise.
// Reset clears the control state, the pass counter and the registers
// (table size 65536, seven probes, seed zero); the table itself is not
// cleared and must be loaded before it is queried. While the receiver
// stalls, the result register holds; a finished query waits for it.
// Configuration uses the APB port, registers at byte addresses 0, 8, 16.
// ----------------------------------------------------------------------------
module bloom_filter_membership_check import bfmc_pkg::*; #(
   parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF,
   parameter int unsigned MAX_HASHES  = MAX_HASHES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [9:0]         req_word_index,
   input  logic [63:0]        req_word_data,
   input  logic [63:0]        req_key_low,
   input  logic [63:0]        req_key_high,
   input  logic               req_last_in_batch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_present,
   output logic [31:0]        rsp_passes_so_far,
   output logic               rsp_batch_done,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   `include "bloom_filter_membership_check_defines.svh"

   localparam int unsigned AW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

   // Configuration registers.
   logic [16:0] tsb_ff;
   logic [5:0]  hc_ff;
   logic [63:0] seed_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsb_ff  <= SIZE_RESET;
         hc_ff   <= COUNT_RESET;
         seed_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[4:3])
            REG_TABLE_SIZE: tsb_ff  <= pwdata[16:0];
            REG_HASH_COUNT: hc_ff   <= pwdata[5:0];
            REG_HASH_SEED:  seed_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_TABLE_SIZE: prdata = {47'd0, tsb_ff};
         REG_HASH_COUNT: prdata = {58'd0, hc_ff};
         REG_HASH_SEED:  prdata = seed_ff;
         default:        prdata = '0;
      endcase
   end

   // Control state.
   ctl_state_type state_ff, state_in;
   logic        req_take, is_load, is_query, load_in_range;
   logic        hash_done;
   logic [63:0] h1, h2;

   logic [16:0]       size_ff, rem_h1_ff, rem_h2_ff, rem_k_ff;
   logic [63:0]       dv_h1_ff, dv_h2_ff, dv_k_ff, raw_ff, step64_ff;
   logic [3:0]        mod_cnt_ff;
   logic [HCNT_W-1:0] n_ff, iss_cnt_ff;
   logic              last_ff, miss_ff;
   logic [31:0]       pass_ff, pass_new;
   logic              out_free, probe_issue, probe_drained, present_now;

   logic [63:0]  mem [TABLE_WORDS];
   logic [63:0]  mem_q_ff;
   logic [AW-1:0] rd_addr;
   logic [10:0]  probe_word;
   logic         probe_in_range;
   logic         rd_vld_ff, rd_oob_ff;
   logic [5:0]   rd_bit_ff;

   logic [16:0] r1_next, r2_next, r3_next, pos_next;
   logic [17:0] pos_sum, pos_red;
   logic [64:0] raw_sum;

   logic        rsp_valid_ff, rsp_present_ff, rsp_batch_ff;
   logic [31:0] rsp_passes_ff;

   // One restoring-division step: shift in a bit, subtract the size if it fits.
   function automatic logic [16:0] mod_step(input logic [16:0] r, input logic b,
                                            input logic [16:0] d);
      logic [17:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[16:0];
   endfunction

   function automatic logic [16:0] mod_nibble(input logic [16:0] r,
                                              input logic [3:0] bits,
                                              input logic [16:0] d);
      logic [16:0] x;
      x = r;
      for (int s = 3; s >= 0; s--) begin
         x = mod_step(x, bits[s], d);
      end
      return x;
   endfunction

   assign r1_next = mod_nibble(rem_h1_ff, dv_h1_ff[63:60], size_ff);
   assign r2_next = mod_nibble(rem_h2_ff, dv_h2_ff[63:60], size_ff);
   assign r3_next = mod_nibble(rem_k_ff,  dv_k_ff[63:60],  size_ff);

   // During probing rem_h1_ff holds the current position, rem_h2_ff holds
   // h2 mod size and rem_k_ff holds 2^64 mod size, which corrects a wrap of
   // the 64-bit running sum.
   assign raw_sum = {1'b0, raw_ff} + {1'b0, step64_ff};
   always_comb begin
      pos_sum = {1'b0, rem_h1_ff} + {1'b0, rem_h2_ff};
      if (pos_sum >= {1'b0, size_ff}) pos_sum = pos_sum - {1'b0, size_ff};
      pos_red = pos_sum;
      if (raw_sum[64]) begin
         if (pos_sum[16:0] >= rem_k_ff) begin
            pos_red = pos_sum - {1'b0, rem_k_ff};
         end else begin
            pos_red = pos_sum + {1'b0, size_ff} - {1'b0, rem_k_ff};
         end
      end
      pos_next = pos_red[16:0];
   end

   assign probe_word     = rem_h1_ff[16:6];
   assign probe_in_range = {6'd0, probe_word} < SIZE_W'(TABLE_WORDS);
   assign rd_addr        = AW'(probe_word);

   assign req_take      = req_valid && !req_stall;
   assign is_load       = req_take && (req_op == OP_LOAD);
   assign is_query      = req_take && (req_op == OP_QUERY);
   assign load_in_range = {7'd0, req_word_index} < SIZE_W'(TABLE_WORDS);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign probe_issue   = (state_ff == ST_PROBE) && (iss_cnt_ff < n_ff);
   assign probe_drained = (iss_cnt_ff == n_ff) && !rd_vld_ff;
   assign present_now   = !miss_ff;
   assign pass_new      = (present_now && (pass_ff != 32'hFFFF_FFFF)) ?
                          pass_ff + 32'd1 : pass_ff;

   bfmc_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (is_query),
      .seed     (seed_ff),
      .key_low  (req_key_low),
      .key_high (req_key_high),
      .done     (hash_done),
      .h1       (h1),
      .h2       (h2)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (is_query) state_in = ST_HASH;
         ST_HASH:  if (hash_done) state_in = ST_MOD;
         ST_MOD:   if (mod_cnt_ff == 4'd15) state_in = ST_PROBE;
         ST_PROBE: if (probe_drained) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= probe_issue;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
            pass_ff      <= last_ff ? 32'd0 : pass_new;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Query datapath.
   always_ff @(posedge clock) begin
      if (is_query) begin
         last_ff <= req_last_in_batch;
         size_ff <= (tsb_ff == 17'd0) ? 17'd1 : tsb_ff;
         n_ff    <= ({1'b0, hc_ff} > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES)
                                                           : {1'b0, hc_ff};
      end
      unique case (state_ff)
         ST_HASH: begin
            if (hash_done) begin
               dv_h1_ff   <= h1;
               dv_h2_ff   <= h2;
               dv_k_ff    <= 64'd0 - {47'd0, size_ff};
               raw_ff     <= h1;
               step64_ff  <= h2;
               rem_h1_ff  <= '0;
               rem_h2_ff  <= '0;
               rem_k_ff   <= '0;
               mod_cnt_ff <= '0;
            end
         end
         ST_MOD: begin
            rem_h1_ff  <= r1_next;
            rem_h2_ff  <= r2_next;
            rem_k_ff   <= r3_next;
            dv_h1_ff   <= dv_h1_ff << 4;
            dv_h2_ff   <= dv_h2_ff << 4;
            dv_k_ff    <= dv_k_ff << 4;
            mod_cnt_ff <= mod_cnt_ff + 4'd1;
            iss_cnt_ff <= '0;
            miss_ff    <= 1'b0;
         end
         ST_PROBE: begin
            if (probe_issue) begin
               rd_oob_ff  <= !probe_in_range;
               rd_bit_ff  <= rem_h1_ff[5:0];
               rem_h1_ff  <= pos_next;
               raw_ff     <= raw_sum[63:0];
               iss_cnt_ff <= iss_cnt_ff + HCNT_W'(1);
            end
            if (rd_vld_ff && (rd_oob_ff || !mem_q_ff[rd_bit_ff])) miss_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // Bit table memory.
   always_ff @(posedge clock) begin
      if (is_load && load_in_range) mem[AW'(req_word_index)] <= req_word_data;
      if (probe_issue) mem_q_ff <= mem[rd_addr];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_present_ff <= present_now;
         rsp_passes_ff  <= pass_new;
         rsp_batch_ff   <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_present       = rsp_present_ff;
   assign rsp_passes_so_far = rsp_passes_ff;
   assign rsp_batch_done    = rsp_batch_ff;

   `BFMC_ASSERT_NOW(a_issue_bound, 1'b1, iss_cnt_ff <= n_ff || state_ff != ST_PROBE,
      "probe issue count passed the hash count")
   `BFMC_ASSERT_NOW(a_done_drained, state_ff == ST_PROBE && state_in == ST_DONE,
      !rd_vld_ff, "probing ended with a table read in flight")
   `BFMC_ASSERT_NOW(a_hash_state, hash_done, state_ff == ST_HASH,
      "hash finished outside the hash phase")
   `BFMC_ASSERT_NOW(a_pass_count, rsp_valid_ff && rsp_present_ff, rsp_passes_ff != 32'd0,
      "present result with a zero pass count")

endmodule

### design/bfmc_hash.sv
// ----------------------------------------------------------------------------
// bfmc_hash: seeded 128-bit key hash
// Computes h1 and h2 of a 16-byte key with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module bfmc_hash import bfmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] seed,
   input  logic [63:0] key_low,
   input  logic [63:0] key_high,
   output logic        done,
   output logic [63:0] h1,
   output logic [63:0] h2
);

   hash_state_type state_ff, state_in;
   logic [2:0]   job_ff;
   logic [1:0]   part_ff;
   logic [1:0]   last_part;
   logic [63:0]  a_ff, b_ff, prod_ff, hi_in_ff, mlo_ff, mhi_ff, rlo_ff, rhi_ff;
   logic [63:0]  h1_ff, h2_ff;
   logic [127:0] acc_ff, acc_add;
   logic [31:0]  a_sel, b_sel;
   logic [63:0]  fin;
   logic         done_ff;

   function automatic logic [63:0] bswap(input logic [63:0] x);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = x[8*(7-i) +: 8];
      end
      return r;
   endfunction

   always_comb begin
      unique case (job_ff)
         3'd1:    last_part = 2'd0;
         3'd0,
         3'd2:    last_part = 2'd3;
         default: last_part = 2'd2;
      endcase
   end

   assign a_sel = part_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_sel = part_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      unique case (part_ff)
         2'd0:       acc_add = {64'd0, prod_ff};
         2'd1, 2'd2: acc_add = {32'd0, prod_ff, 32'd0};
         default:    acc_add = {prod_ff, 64'd0};
      endcase
   end

   assign fin = acc_ff[63:0] ^ (acc_ff[63:0] >> 32);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         HS_IDLE:  if (start) state_in = HS_MUL;
         HS_MUL:   state_in = HS_ACC;
         HS_ACC:   if (part_ff == last_part) state_in = HS_SETUP;
                   else state_in = HS_MUL;
         HS_SETUP: if (job_ff == 3'd5) state_in = HS_IDLE;
                   else state_in = HS_MUL;
         default:  state_in = HS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == HS_SETUP) && (job_ff == 3'd5);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               a_ff     <= key_low ^ key_high ^ (SEC_A - seed);
               b_ff     <= PR64_1;
               acc_ff   <= '0;
               hi_in_ff <= key_high ^ (SEC_B + seed);
               job_ff   <= 3'd0;
               part_ff  <= 2'd0;
            end
         end
         HS_MUL: prod_ff <= 64'(a_sel * b_sel);
         HS_ACC: begin
            acc_ff <= acc_ff + acc_add;
            if (part_ff != last_part) part_ff <= part_ff + 2'd1;
         end
         HS_SETUP: begin
            part_ff <= 2'd0;
            job_ff  <= job_ff + 3'd1;
            unique case (job_ff)
               3'd0: begin
                  mlo_ff <= acc_ff[63:0] + (64'd15 << 54);
                  a_ff   <= {32'd0, hi_in_ff[31:0]};
                  b_ff   <= PR32_2M1;
                  acc_ff <= {64'd0, acc_ff[127:64] + hi_in_ff};
               end
               3'd1: begin
                  mhi_ff <= acc_ff[63:0];
                  a_ff   <= mlo_ff ^ bswap(acc_ff[63:0]);
                  b_ff   <= PR64_2;
                  acc_ff <= '0;
               end
               3'd2: begin
                  rlo_ff <= acc_ff[63:0];
                  a_ff   <= mhi_ff;
                  b_ff   <= PR64_2;
                  acc_ff <= {64'd0, acc_ff[127:64]};
               end
               3'd3: begin
                  rhi_ff <= acc_ff[63:0];
                  a_ff   <= rlo_ff ^ (rlo_ff >> 37);
                  b_ff   <= AVAL_MUL;
                  acc_ff <= '0;
               end
               3'd4: begin
                  h1_ff  <= fin;
                  a_ff   <= rhi_ff ^ (rhi_ff >> 37);
                  acc_ff <= '0;
               end
               default: h2_ff <= fin | 64'd1;
            endcase
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign h1   = h1_ff;
   assign h2   = h2_ff;

endmodule

### test/bloom_filter_membership_check_checker.sv
// ----------------------------------------------------------------------------
// bloom_filter_membership_check_checker: result predictor and comparator
// Watches the request, result and register ports of the Bloom membership
// check. It mirrors the table and registers and hashes every query key to
// predict its result, then compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bloom_filter_membership_check_checker import bfmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_op,
   input  logic [9:0]         req_word_index,
   input  logic [63:0]        req_word_data,
   input  logic [63:0]        req_key_low,
   input  logic [63:0]        req_key_high,
   input  logic               req_last_in_batch,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_present,
   input  logic [31:0]        rsp_passes_so_far,
   input  logic               rsp_batch_done,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [63:0]        pwdata,
   input  logic               pready,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        present;
      logic [31:0] passes;
      logic        done;
   } membership_type;

   logic [63:0]    bit_table [TABLE_WORDS_DEF];
   logic [31:0]    batch_passes;
   logic [16:0]    size_reg;
   logic [5:0]     probes_reg;
   logic [63:0]    seed_reg;
   membership_type membership_q[$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic logic [63:0] avalanche(input logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> 37);
      x = x * AVAL_MUL;
      return x ^ (x >> 32);
   endfunction

   // Seeded 128-bit hash of a 16-byte key.
   task automatic hash_key(input logic [63:0] klo, input logic [63:0] khi,
                           input logic [63:0] seed,
                           output logic [63:0] h1, output logic [63:0] h2);
      logic [127:0] m;
      logic [127:0] r;
      logic [63:0]  m_lo;
      logic [63:0]  m_hi;
      logic [63:0]  hi_in;
      logic [63:0]  swapped;
      logic [63:0]  r_hi;
      m = 128'(klo ^ khi ^ (SEC_A - seed)) * 128'(PR64_1);
      m_lo = m[63:0] + (64'd15 << 54);
      hi_in = khi ^ (SEC_B + seed);
      m_hi = m[127:64] + hi_in + {32'd0, hi_in[31:0]} * PR32_2M1;
      for (int j = 0; j < 8; j++) begin
         swapped[8*j +: 8] = m_hi[8*(7-j) +: 8];
      end
      m_lo = m_lo ^ swapped;
      r = 128'(m_lo) * 128'(PR64_2);
      r_hi = r[127:64] + m_hi * PR64_2;
      h1 = avalanche(r[63:0]);
      h2 = avalanche(r_hi);
   endtask

   task automatic predict_query();
      logic [63:0]    h1;
      logic [63:0]    h2;
      logic [63:0]    span;
      logic [63:0]    pos;
      logic [63:0]    word;
      int unsigned    n;
      logic           hit;
      membership_type m;
      hash_key(req_key_low, req_key_high, seed_reg, h1, h2);
      h2[0] = 1'b1;
      span = (size_reg == 0) ? 64'd1 : 64'(size_reg);
      n = (probes_reg > MAX_HASHES_DEF) ? MAX_HASHES_DEF : probes_reg;
      hit = 1'b1;
      for (int unsigned i = 0; i < n && hit; i++) begin
         pos = (h1 + 64'(i) * h2) % span;
         // Probes past the end of the table read as clear bits.
         word = ((pos >> 6) < TABLE_WORDS_DEF) ? bit_table[pos >> 6] : 64'd0;
         hit = word[pos[5:0]];
      end
      if (hit && batch_passes != 32'hFFFFFFFF) begin
         batch_passes++;
      end
      m.present = hit;
      m.passes = batch_passes;
      m.done = req_last_in_batch;
      membership_q.push_back(m);
      if (req_last_in_batch) begin
         batch_passes = 0;
      end
   endtask

   always @(posedge clock) begin
      membership_type m;
      if (reset) begin
         batch_passes = 0;
         size_reg = SIZE_RESET;
         probes_reg = COUNT_RESET;
         seed_reg = 64'd0;
         membership_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_TABLE_SIZE: size_reg = pwdata[16:0];
               REG_HASH_COUNT: probes_reg = pwdata[5:0];
               REG_HASH_SEED:  seed_reg = pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_LOAD) begin
               bit_table[req_word_index] = req_word_data;
            end else begin
               predict_query();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (membership_q.size() == 0) begin
               $error("result transfer with no query outstanding");
               fail_count++;
            end else begin
               m = membership_q.pop_front();
               if (rsp_present !== m.present) begin
                  $error("present: expected %0d, actual %0d", m.present, rsp_present);
                  fail_count++;
               end
               if (rsp_passes_so_far !== m.passes) begin
                  $error("passes_so_far: expected %0d, actual %0d",
                         m.passes, rsp_passes_so_far);
                  fail_count++;
               end
               if (rsp_batch_done !== m.done) begin
                  $error("batch_done: expected %0d, actual %0d", m.done, rsp_batch_done);
                  fail_count++;
               end
            end
         end
      end
      pending = membership_q.size();
   end

endmodule

### test/bloom_filter_membership_check_tb.sv
// ----------------------------------------------------------------------------
// bloom_filter_membership_check_tb: testbench top of the Bloom membership check
// Loads the whole table, runs directed corner cases and then phases of random
// loads and query batches under several register settings and idle patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bloom_filter_membership_check_tb;
   import bfmc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   // Settle wait after the last result, well beyond the full run of one query.
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES = 400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_op;
   logic [9:0]         req_word_index;
   logic [63:0]        req_word_data;
   logic [63:0]        req_key_low;
   logic [63:0]        req_key_high;
   logic               req_last_in_batch;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_present;
   logic [31:0]        rsp_passes_so_far;
   logic               rsp_batch_done;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [63:0]        pwdata;
   logic [63:0]        prdata;
   logic               pready;

   int fail_count;
   int pending;
   int cycle_count;
   // Percent chances of a sender gap and of a receiver stall in each cycle.
   int send_idle_pct;
   int stall_pct;
   // The top asks for a long receiver hold-off by bumping hold_requests;
   // the receiver process counts the stretch out on its own.
   int hold_requests;
   int hold_served;
   int hold_left;

   bloom_filter_membership_check i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_word_index    (req_word_index),
      .req_word_data     (req_word_data),
      .req_key_low       (req_key_low),
      .req_key_high      (req_key_high),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_present       (rsp_present),
      .rsp_passes_so_far (rsp_passes_so_far),
      .rsp_batch_done    (rsp_batch_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   bloom_filter_membership_check_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_word_index    (req_word_index),
      .req_word_data     (req_word_data),
      .req_key_low       (req_key_low),
      .req_key_high      (req_key_high),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_present       (rsp_present),
      .rsp_passes_so_far (rsp_passes_so_far),
      .rsp_batch_done    (rsp_batch_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // The run is cut off if it hangs anywhere.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: stalls at random, or for a whole stretch when a hold-off is asked.
   initial begin
      rsp_stall = 1'b0;
      hold_served = 0;
      hold_left = 0;
   end
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Table word whose density of set bits varies: ORing more random words
   // gives fuller words, so that both present and absent keys are common.
   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = rand64();
      repeat ($urandom_range(5)) w = w | rand64();
      return w;
   endfunction

   // One transfer on the request channel. Valid stays high when the next
   // transfer follows without a gap.
   task automatic send_item(input logic op, input logic [9:0] idx,
                            input logic [63:0] data, input logic [63:0] klo,
                            input logic [63:0] khi, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_word_index <= idx;
      req_word_data <= data;
      req_key_low <= klo;
      req_key_high <= khi;
      req_last_in_batch <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic query_key(input logic [63:0] klo, input logic [63:0] khi,
                            input logic last);
      send_item(OP_QUERY, 10'($urandom), rand64(), klo, khi, last);
   endtask

   // Wait until every query has its result and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(index) << 3;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [16:0] bits, input logic [5:0] probes,
                            input logic [63:0] seed);
      csr_write(REG_TABLE_SIZE, 64'(bits));
      csr_write(REG_HASH_COUNT, 64'(probes));
      csr_write(REG_HASH_SEED, seed);
   endtask

   initial begin
      logic [16:0] sizes [6];
      logic [5:0]  counts [6];
      logic [63:0] seeds [6];
      logic [63:0] klo;
      logic [63:0] khi;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_LOAD;
      req_word_index = '0;
      req_word_data = '0;
      req_key_low = '0;
      req_key_high = '0;
      req_last_in_batch = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The table is never cleared, so every word is written before any query.
      for (int w = 0; w < TABLE_WORDS_DEF; w++) begin
         send_item(OP_LOAD, 10'(w), rand_word(), rand64(), rand64(), w[0]);
      end

      // Directed part under the reset settings: extreme words and keys,
      // batch ends, and a load carrying the last mark.
      send_item(OP_LOAD, 10'd0, 64'hFFFFFFFFFFFFFFFF, 64'd0, 64'd0, 1'b1);
      send_item(OP_LOAD, 10'd1023, 64'hFFFFFFFFFFFFFFFF, '1, '1, 1'b0);
      query_key(64'd0, 64'd0, 1'b0);
      query_key('1, '1, 1'b0);
      query_key(64'd0, '1, 1'b1);
      query_key('1, 64'd0, 1'b1);
      send_item(OP_LOAD, 10'd511, 64'd0, 64'd0, 64'd0, 1'b1);
      settle();
      // No probes at all: every key is present.
      configure(17'd65536, 6'd0, '1);
      query_key(rand64(), rand64(), 1'b0);
      query_key(rand64(), rand64(), 1'b0);
      query_key(rand64(), rand64(), 1'b1);
      settle();
      // A table size of zero behaves as one bit; word 0 is all ones.
      configure(17'd0, 6'd32, 64'd0);
      query_key(rand64(), rand64(), 1'b0);
      query_key(rand64(), rand64(), 1'b1);
      settle();
      // Too many probes saturate, and an oversized table reads clear past its end.
      configure(17'h1FFFF, 6'd63, rand64());
      query_key(rand64(), rand64(), 1'b0);
      query_key(rand64(), rand64(), 1'b1);
      settle();

      // Random phases, each with its own register setting and idle pattern.
      sizes = '{17'd65536, 17'd1, 17'd1000, 17'h1FFFF, 17'd65536, 17'd64};
      counts = '{6'd7, 6'd1, 6'd3, 6'd63, 6'd32, 6'd2};
      seeds = '{64'd0, '1, rand64(), rand64(), rand64(), rand64()};
      for (int p = 0; p < 6; p++) begin
         configure(sizes[p], counts[p], seeds[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         // The receiver holds off while queries keep coming, so the block fills.
         if (p == 2) begin
            hold_requests++;
         end
         for (int n = 0; n < 20; n++) begin
            if (n == 10) begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            if ($urandom_range(99) < 20) begin
               send_item(OP_LOAD, 10'($urandom), rand_word(), rand64(), rand64(),
                         1'($urandom));
            end else begin
               klo = rand64();
               khi = rand64();
               query_key(klo, khi, $urandom_range(7) == 0);
               // Asking the same key again tests the same probe positions.
               if ($urandom_range(9) == 0) begin
                  query_key(klo, khi, 1'($urandom));
               end
            end
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/bfmc_pkg.sv
design/bfmc_hash.sv
design/bloom_filter_membership_check.sv
test/bloom_filter_membership_check_checker.sv
test/bloom_filter_membership_check_tb.sv
